[sv/ptsm_pkg.sv]
// shared constants and codes for the prefix table string matcher
package ptsm_pkg;

  localparam int PATTERN_MAX_DEF   = 64;
  localparam int POSITION_BITS_DEF = 32;

  localparam logic MODE_PATTERN = 1'b0;
  localparam logic MODE_TEXT    = 1'b1;

  localparam logic [1:0] STATUS_STORED  = 2'd0;
  localparam logic [1:0] STATUS_DROPPED = 2'd1;
  localparam logic [1:0] STATUS_NOMATCH = 2'd2;
  localparam logic [1:0] STATUS_MATCH   = 2'd3;

endpackage

[sv/ptsm_tables.sv]
// pattern byte memory and failure table memory, one read and one write port each
module ptsm_tables #(
  parameter int PATTERN_MAX = ptsm_pkg::PATTERN_MAX_DEF
) (
  input  logic                                 clk_i,
  input  logic [$clog2(PATTERN_MAX + 1) - 1:0] rd_addr_i,
  input  logic                                 wr_en_i,
  input  logic [$clog2(PATTERN_MAX + 1) - 1:0] wr_addr_i,
  input  logic [7:0]                           wr_byte_i,
  input  logic [$clog2(PATTERN_MAX + 1) - 1:0] wr_fail_i,
  output logic [7:0]                           pat_rdata_o,
  output logic [$clog2(PATTERN_MAX + 1) - 1:0] fail_rdata_o
);

  localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);
  localparam int PAW      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  logic [7:0]          pat_mem  [PATTERN_MAX];
  logic [LEN_BITS-1:0] fail_mem [PATTERN_MAX + 1];

  logic [LEN_BITS-1:0] fail_wr_addr;

  // entry i+1 of the failure table belongs to pattern byte i
  assign fail_wr_addr = wr_addr_i + LEN_BITS'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pat_mem[wr_addr_i[PAW-1:0]] <= wr_byte_i;
      fail_mem[fail_wr_addr]      <= wr_fail_i;
    end
    pat_rdata_o  <= pat_mem[rd_addr_i[PAW-1:0]];
    fail_rdata_o <= fail_mem[rd_addr_i];
  end

endmodule

[sv/prefix_table_string_matcher_core.sv]
// Morris-Pratt single pattern matcher: pattern loading, text search and result register
// Pattern bytes (mode 0) extend the stored pattern and build its failure table; text
// bytes (mode 1) are searched against it, and each transaction returns exactly one
// result: status, start index of a match ending at this byte, and the text index.
// One transaction is handled at a time. Dropped pattern bytes, the first byte of a
// pattern and text with an empty pattern go from the idle state straight to the done
// state and then to the output register; every other transaction first passes through
// the walk state, making k >= 1 compare steps along the failure chain (one read each
// through the single read port of the pattern and failure memories). The input stalls
// until the result is in the output register, which waits while that register holds an
// unaccepted result. Over a text stream k averages at most two per byte.
module prefix_table_string_matcher_core #(
  parameter int PATTERN_MAX   = ptsm_pkg::PATTERN_MAX_DEF,
  parameter int POSITION_BITS = ptsm_pkg::POSITION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic        start_req_i,
  input  logic [7:0]  byte_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] match_start_o,
  output logic [31:0] text_index_o
);

  localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  state_e                  state_q, state_d;
  logic                    mode_q, mode_d;
  logic [7:0]              byte_q, byte_d;
  logic [LEN_BITS-1:0]     walk_q, walk_d;
  logic [LEN_BITS-1:0]     res_q, res_d;
  logic [1:0]              status_q, status_d;
  logic [POSITION_BITS-1:0] mstart_q, mstart_d;
  logic [POSITION_BITS-1:0] tindex_q, tindex_d;
  logic [LEN_BITS-1:0]     plen_q, plen_d;
  logic [LEN_BITS-1:0]     bp_q, bp_d;
  logic                    bp_valid_q, bp_valid_d;
  logic [LEN_BITS-1:0]     mlen_q, mlen_d;
  logic [POSITION_BITS-1:0] tcnt_q, tcnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              out_status_q, out_status_d;
  logic [31:0]             out_mstart_q, out_mstart_d;
  logic [31:0]             out_tindex_q, out_tindex_d;

  logic [LEN_BITS-1:0]     rd_addr;
  logic                    wr_en;
  logic [7:0]              pat_rdata;
  logic [LEN_BITS-1:0]     fail_rdata;

  logic [LEN_BITS-1:0]     eff_plen;
  logic                    eff_bp_valid;
  logic [POSITION_BITS-1:0] idx;
  logic [LEN_BITS-1:0]     walk_start;
  logic                    hit;
  logic [LEN_BITS-1:0]     walk_res;
  logic [63:0]             mstart_wide;
  logic [63:0]             tindex_wide;

  ptsm_tables #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_tables (
    .clk_i        (clk_i),
    .rd_addr_i    (rd_addr),
    .wr_en_i      (wr_en),
    .wr_addr_i    (plen_q),
    .wr_byte_i    (byte_q),
    .wr_fail_i    (res_q),
    .pat_rdata_o  (pat_rdata),
    .fail_rdata_o (fail_rdata)
  );

  assign eff_plen     = start_req_i ? '0 : plen_q;
  assign eff_bp_valid = start_req_i ? 1'b0 : bp_valid_q;
  assign idx          = start_req_i ? '0 : tcnt_q;
  assign walk_start   = start_req_i ? '0 : mlen_q;
  assign hit          = (pat_rdata == byte_q);
  assign walk_res     = hit ? (walk_q + LEN_BITS'(1)) : '0;
  assign mstart_wide  = 64'(mstart_q);
  assign tindex_wide  = 64'(tindex_q);

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    byte_d       = byte_q;
    walk_d       = walk_q;
    res_d        = res_q;
    status_d     = status_q;
    mstart_d     = mstart_q;
    tindex_d     = tindex_q;
    plen_d       = plen_q;
    bp_d         = bp_q;
    bp_valid_d   = bp_valid_q;
    mlen_d       = mlen_q;
    tcnt_d       = tcnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_mstart_d = out_mstart_q;
    out_tindex_d = out_tindex_q;
    rd_addr      = walk_q;
    wr_en        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d   = mode_i;
          byte_d   = byte_value_i;
          mstart_d = '0;
          tindex_d = '0;
          res_d    = '0;
          if (mode_i == ptsm_pkg::MODE_PATTERN) begin
            mlen_d = '0;
            tcnt_d = '0;
            if (start_req_i) begin
              plen_d     = '0;
              bp_valid_d = 1'b0;
            end
            if (eff_plen >= LEN_BITS'(PATTERN_MAX)) begin
              status_d = ptsm_pkg::STATUS_DROPPED;
              state_d  = ST_DONE;
            end else begin
              status_d = ptsm_pkg::STATUS_STORED;
              if (eff_bp_valid) begin
                walk_d  = bp_q;
                rd_addr = bp_q;
                state_d = ST_WALK;
              end else begin
                state_d = ST_DONE;
              end
            end
          end else begin
            tindex_d = idx;
            tcnt_d   = (idx == POS_MAX) ? idx : idx + POSITION_BITS'(1);
            status_d = ptsm_pkg::STATUS_NOMATCH;
            mlen_d   = walk_start;
            if (plen_q != '0) begin
              walk_d  = walk_start;
              rd_addr = walk_start;
              state_d = ST_WALK;
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end
      ST_WALK: begin
        if (hit || walk_q == '0) begin
          state_d = ST_DONE;
          if (mode_q == ptsm_pkg::MODE_PATTERN) begin
            res_d = walk_res;
          end else if (walk_res == plen_q) begin
            status_d = ptsm_pkg::STATUS_MATCH;
            mstart_d = tindex_q - POSITION_BITS'(plen_q) + POSITION_BITS'(1);
            mlen_d   = bp_q;
          end else begin
            mlen_d = walk_res;
          end
        end else begin
          walk_d  = fail_rdata;
          rd_addr = fail_rdata;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_mstart_d = mstart_wide[31:0];
          out_tindex_d = tindex_wide[31:0];
          if (mode_q == ptsm_pkg::MODE_PATTERN && status_q == ptsm_pkg::STATUS_STORED) begin
            wr_en      = 1'b1;
            plen_d     = plen_q + LEN_BITS'(1);
            bp_d       = res_q;
            bp_valid_d = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      mode_q       <= ptsm_pkg::MODE_PATTERN;
      byte_q       <= '0;
      walk_q       <= '0;
      res_q        <= '0;
      status_q     <= ptsm_pkg::STATUS_STORED;
      mstart_q     <= '0;
      tindex_q     <= '0;
      plen_q       <= '0;
      bp_q         <= '0;
      bp_valid_q   <= 1'b0;
      mlen_q       <= '0;
      tcnt_q       <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ptsm_pkg::STATUS_STORED;
      out_mstart_q <= '0;
      out_tindex_q <= '0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      byte_q       <= byte_d;
      walk_q       <= walk_d;
      res_q        <= res_d;
      status_q     <= status_d;
      mstart_q     <= mstart_d;
      tindex_q     <= tindex_d;
      plen_q       <= plen_d;
      bp_q         <= bp_d;
      bp_valid_q   <= bp_valid_d;
      mlen_q       <= mlen_d;
      tcnt_q       <= tcnt_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_mstart_q <= out_mstart_d;
      out_tindex_q <= out_tindex_d;
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign match_start_o = out_mstart_q;
  assign text_index_o  = out_tindex_q;

endmodule

[sim/prefix_table_string_matcher_core_checker.sv]
// result checker for the prefix table string matcher: predicts every transaction and compares
`timescale 1ns / 1ps

module ptsm_match_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        mode_i,
  input  logic        start_req_i,
  input  logic [7:0]  byte_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] match_start_i,
  input  logic [31:0] text_index_i,
  output int          mismatch_count_o,
  output int          pending_count_o,
  output int          match_count_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] match_start;
    logic [31:0] text_index;
  } match_result_t;

  logic [7:0]    pat_mem [ptsm_pkg::PATTERN_MAX_DEF];
  int            fail_tab [ptsm_pkg::PATTERN_MAX_DEF + 1];
  int            pat_len;
  int            build_pfx;
  int            match_len;
  logic [31:0]   text_cnt;
  match_result_t expected_results [$];

  function automatic match_result_t next_match_result(input logic m, input logic s,
                                                      input logic [7:0] b);
    match_result_t r;
    int            j;
    int            q;
    logic [31:0]   idx;
    r = '0;
    if (m == ptsm_pkg::MODE_PATTERN) begin
      if (s) begin
        pat_len     = 0;
        build_pfx   = -1;
        fail_tab[0] = -1;
      end
      match_len = 0;
      text_cnt  = '0;
      if (pat_len >= ptsm_pkg::PATTERN_MAX_DEF) begin
        r.status = ptsm_pkg::STATUS_DROPPED;
      end else begin
        pat_mem[pat_len] = b;
        j = build_pfx;
        while (j > -1 && pat_mem[pat_len] != pat_mem[j]) j = fail_tab[j];
        j++;
        fail_tab[pat_len + 1] = j;
        build_pfx = j;
        pat_len++;
        r.status = ptsm_pkg::STATUS_STORED;
      end
    end else begin
      if (s) begin
        match_len = 0;
        text_cnt  = '0;
      end
      idx = text_cnt;
      if (text_cnt != '1) text_cnt++;
      r.text_index = idx;
      r.status     = ptsm_pkg::STATUS_NOMATCH;
      if (pat_len > 0) begin
        q = match_len;
        while (q > -1 && pat_mem[q] != b) q = fail_tab[q];
        q++;
        if (q == pat_len) begin
          r.status      = ptsm_pkg::STATUS_MATCH;
          r.match_start = idx - 32'(pat_len) + 32'd1;
          q = fail_tab[pat_len];
        end
        match_len = q;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    match_result_t exp_r;
    if (!rst_ni) begin
      pat_len     = 0;
      build_pfx   = -1;
      fail_tab[0] = -1;
      match_len   = 0;
      text_cnt    = '0;
      expected_results.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
      match_count_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction pending: status %0d", status_i);
          mismatch_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (status_i !== exp_r.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp_r.status, status_i);
            mismatch_count_o++;
          end
          if (match_start_i !== exp_r.match_start) begin
            $error("match_start mismatch: expected %0d, actual %0d",
                   exp_r.match_start, match_start_i);
            mismatch_count_o++;
          end
          if (text_index_i !== exp_r.text_index) begin
            $error("text_index mismatch: expected %0d, actual %0d",
                   exp_r.text_index, text_index_i);
            mismatch_count_o++;
          end
          if (exp_r.status == ptsm_pkg::STATUS_MATCH) match_count_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        exp_r = next_match_result(mode_i, start_req_i, byte_value_i);
        expected_results = {expected_results, exp_r};
      end
      pending_count_o = expected_results.size();
    end
  end

endmodule

[sim/prefix_table_string_matcher_core_test.sv]
// testbench top for the prefix table string matcher: stimulus, stall patterns and verdict
`timescale 1ns / 1ps

module prefix_table_string_matcher_core_test;

  localparam int ITEM_TARGET    = 550;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 100;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        mode;
  logic        start_req;
  logic [7:0]  byte_value;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] match_start;
  logic [31:0] text_index;

  int mismatches;
  int pending;
  int match_total;
  int items_sent;
  int pattern_sent;
  int text_sent;
  int burst_left;
  int idle_cycles = 0;
  int stall_phase_left = 0;
  int stall_kind = 0;
  int sessions;

  prefix_table_string_matcher_core i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .mode_i        (mode),
    .start_req_i   (start_req),
    .byte_value_i  (byte_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .match_start_o (match_start),
    .text_index_o  (text_index)
  );

  ptsm_match_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .mode_i           (mode),
    .start_req_i      (start_req),
    .byte_value_i     (byte_value),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .match_start_i    (match_start),
    .text_index_i     (text_index),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending),
    .match_count_o    (match_total)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_kind       = $urandom_range(0, 3);
      stall_phase_left = $urandom_range(20, 200);
    end
    stall_phase_left--;
    case (stall_kind)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_phase_left[0];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // one transaction, called and returning at a falling edge
  task automatic send_item(input logic m, input logic s, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    mode       = m;
    start_req  = s;
    byte_value = b;
    in_valid   = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
    if (m == ptsm_pkg::MODE_PATTERN) pattern_sent++;
    else text_sent++;
  endtask

  task automatic pattern_text_session(input bit force_long);
    logic [7:0] alpha [3];
    logic [7:0] pat [$];
    logic [7:0] b;
    int         n_alpha;
    int         plen;
    int         tlen;
    int         k;
    bit         fresh_text;
    bit         fresh_pat;
    n_alpha = $urandom_range(1, 3);
    foreach (alpha[i]) alpha[i] = 8'($urandom);
    plen = (force_long || $urandom_range(0, 11) == 0) ? $urandom_range(60, 70)
                                                        : $urandom_range(1, 6);
    fresh_pat = ($urandom_range(0, 4) != 0);
    for (k = 0; k < plen; k++) begin
      b = alpha[$urandom_range(0, n_alpha - 1)];
      if (k < ptsm_pkg::PATTERN_MAX_DEF) pat = {pat, b};
      send_item(ptsm_pkg::MODE_PATTERN, fresh_pat && k == 0, b);
    end
    tlen       = $urandom_range(8, 40);
    fresh_text = ($urandom_range(0, 4) != 0);
    k = 0;
    while (k < tlen) begin
      if ($urandom_range(0, 2) == 0) begin
        foreach (pat[i]) begin
          send_item(ptsm_pkg::MODE_TEXT, fresh_text && k == 0, pat[i]);
          k++;
        end
      end else begin
        send_item(ptsm_pkg::MODE_TEXT, fresh_text && k == 0,
                  alpha[$urandom_range(0, n_alpha - 1)]);
        k++;
      end
    end
  endtask

  task automatic noise_items();
    int n;
    n = $urandom_range(1, 8);
    repeat (n) send_item(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0, 8'($urandom));
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    mode         = ptsm_pkg::MODE_PATTERN;
    start_req    = 1'b0;
    byte_value   = 8'h00;
    items_sent   = 0;
    pattern_sent = 0;
    text_sent    = 0;
    burst_left   = 0;
    sessions     = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty pattern, text continuing from reset
    send_item(ptsm_pkg::MODE_TEXT, 1'b0, 8'h41);
    // pattern without start after reset extends the empty pattern
    send_item(ptsm_pkg::MODE_PATTERN, 1'b0, 8'h41);
    // byte extremes, nontrivial failure entries
    send_item(ptsm_pkg::MODE_PATTERN, 1'b1, 8'h00);
    send_item(ptsm_pkg::MODE_PATTERN, 1'b0, 8'hFF);
    send_item(ptsm_pkg::MODE_PATTERN, 1'b0, 8'h00);
    // overlapping matches
    send_item(ptsm_pkg::MODE_TEXT, 1'b1, 8'h00);
    send_item(ptsm_pkg::MODE_TEXT, 1'b0, 8'hFF);
    send_item(ptsm_pkg::MODE_TEXT, 1'b0, 8'h00);
    send_item(ptsm_pkg::MODE_TEXT, 1'b0, 8'hFF);
    send_item(ptsm_pkg::MODE_TEXT, 1'b0, 8'h00);
    send_item(ptsm_pkg::MODE_TEXT, 1'b0, 8'h00);
    // pattern load clears the text position
    send_item(ptsm_pkg::MODE_PATTERN, 1'b0, 8'hFF);
    send_item(ptsm_pkg::MODE_TEXT, 1'b0, 8'h00);
    send_item(ptsm_pkg::MODE_TEXT, 1'b0, 8'hFF);
    send_item(ptsm_pkg::MODE_TEXT, 1'b0, 8'h00);
    send_item(ptsm_pkg::MODE_TEXT, 1'b0, 8'hFF);
    // single byte pattern matches every equal byte
    send_item(ptsm_pkg::MODE_PATTERN, 1'b1, 8'hA5);
    send_item(ptsm_pkg::MODE_TEXT, 1'b1, 8'hA5);
    send_item(ptsm_pkg::MODE_TEXT, 1'b0, 8'h5A);
    send_item(ptsm_pkg::MODE_TEXT, 1'b0, 8'hA5);
    send_item(ptsm_pkg::MODE_TEXT, 1'b1, 8'hA5);

    while (items_sent < ITEM_TARGET) begin
      if (sessions > 0 && $urandom_range(0, 4) == 0) begin
        noise_items();
      end else begin
        pattern_text_session(sessions == 0);
        sessions++;
      end
    end

    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("sent %0d transactions (%0d pattern, %0d text) over %0d pattern sessions",
             items_sent, pattern_sent, text_sent, sessions);
    $display("matches reported: %0d, mismatches: %0d, results outstanding: %0d",
             match_total, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
sv/ptsm_pkg.sv
sv/ptsm_tables.sv
sv/prefix_table_string_matcher_core.sv
sim/prefix_table_string_matcher_core_checker.sv
sim/prefix_table_string_matcher_core_test.sv
